[src/ngp_pkg.sv]
// Shared types, character codes and helpers for the GGA sentence parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package ngp_pkg;

  localparam int MAX_FIELDS      = 16;
  localparam int MAX_COORD_CHARS = 15;
  localparam int TEXT_CHARS      = 15;

  // Field numbers of the GGA body.
  localparam logic [4:0] FLD_TALKER = 5'd0;
  localparam logic [4:0] FLD_LAT    = 5'd2;
  localparam logic [4:0] FLD_NS     = 5'd3;
  localparam logic [4:0] FLD_LON    = 5'd4;
  localparam logic [4:0] FLD_EW     = 5'd5;
  localparam logic [4:0] FLD_QUAL   = 5'd6;
  localparam logic [4:0] FLD_SATS   = 5'd7;
  localparam logic [4:0] FLD_MIN_LAST = 5'd9;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UG     = 8'h47;
  localparam logic [7:0] CH_UN     = 8'h4E;
  localparam logic [7:0] CH_US     = 8'h53;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UW     = 8'h57;

  typedef enum logic [7:0] {
    PH_DOLLAR    = 8'b0000_0001,
    PH_BODY      = 8'b0000_0010,
    PH_HEX1      = 8'b0000_0100,
    PH_HEX2      = 8'b0000_1000,
    PH_TAIL      = 8'b0001_0000,
    PH_TAIL_CR   = 8'b0010_0000,
    PH_TAIL_DONE = 8'b0100_0000,
    PH_ENDED     = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } char_beat_t;

  typedef struct packed {
    logic        fix_valid;
    logic [3:0]  fix_quality;
    logic [6:0]  satellite_count;
    logic        south_flag;
    logic        west_flag;
    logic [63:0] lat_text_head;
    logic [55:0] lat_text_tail;
    logic [3:0]  lat_length;
    logic [63:0] lon_text_head;
    logic [55:0] lon_text_tail;
    logic [3:0]  lon_length;
  } result_beat_t;

  // Update that one coordinate character makes to the position state.
  typedef struct packed {
    logic       pos_bad;
    logic       wr_en;
    logic [7:0] deg;
    logic [6:0] mins;
    logic       mnz_set;
  } coord_upd_t;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage
`default_nettype wire

[src/ngp_coord.sv]
// Per-character update of the latitude or longitude field: degrees,
// minute integer part and format checks. Depends on ngp_pkg.
`default_nettype none
module ngp_coord #(
  parameter int MAX_COORD_CHARS = ngp_pkg::MAX_COORD_CHARS
) (
  input  wire logic [4:0]        idx,
  input  wire logic [7:0]        c,
  input  wire logic              is_lon,
  input  wire logic [7:0]        deg,
  input  wire logic [6:0]        mins,
  input  wire logic              dot_at_dig,
  output ngp_pkg::coord_upd_t    upd
);
  import ngp_pkg::*;

  logic [2:0]  dig;
  logic        is_digit;
  logic [3:0]  d;
  logic [11:0] deg_prod;
  logic [10:0] min_prod;

  always_comb begin
    dig      = is_lon ? 3'd5 : 3'd4;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = 4'(c - CH_ZERO);
    deg_prod = 12'(deg) * 12'd10 + 12'(d);
    min_prod = 11'(mins) * 11'd10 + 11'(d);
    upd.pos_bad = 1'b0;
    upd.wr_en   = 1'b0;
    upd.deg     = deg;
    upd.mins    = mins;
    upd.mnz_set = 1'b0;
    if (idx >= 5'(MAX_COORD_CHARS)) begin
      upd.pos_bad = 1'b1;
    end else begin
      upd.wr_en = 1'b1;
      if (!is_digit) begin
        if (!(idx == 5'(dig) && c == CH_DOT)) upd.pos_bad = 1'b1;
      end else if (idx < 5'(dig - 3'd2)) begin
        upd.deg = (deg_prod > 12'd255) ? 8'd255 : deg_prod[7:0];
      end else begin
        upd.mnz_set = (d != 4'd0);
        if (!(idx > 5'(dig) && dot_at_dig))
          upd.mins = (min_prod > 11'd127) ? 7'd127 : min_prod[6:0];
      end
    end
  end

endmodule
`default_nettype wire

[src/ngp_pack.sv]
// Packs captured coordinate text into head and tail words with its length.
// Depends on ngp_pkg.
`default_nettype none
module ngp_pack (
  input  wire logic [7:0]  chars [ngp_pkg::TEXT_CHARS],
  output logic      [63:0] head,
  output logic      [55:0] tail,
  output logic      [3:0]  len
);
  import ngp_pkg::*;

  logic alive;

  // The text runs up to the first zero byte.
  always_comb begin
    alive = 1'b1;
    head  = '0;
    tail  = '0;
    len   = 4'd0;
    for (int i = 0; i < TEXT_CHARS; i++) begin
      if (chars[i] == CH_NUL) alive = 1'b0;
      if (alive) begin
        len = len + 4'd1;
        if (i < 8) head[8*(7-i) +: 8] = chars[i];
        else       tail[8*(14-i) +: 8] = chars[i];
      end
    end
  end

endmodule
`default_nettype wire

[src/nmea_gga_sentence_parser_core.sv]
// The result beat is registered from the end_of_line byte and appears in the cycle after that byte is taken.
// Throughput: one byte per cycle as long as the result side takes each result beat.
// The input stalls only while a finished result sits unaccepted in the output register.
// Reset (rst, synchronous, active high) returns parsing to "expect dollar" and
// drops any pending result. Depends on ngp_pkg, ngp_coord and ngp_pack.
`default_nettype none
module nmea_gga_sentence_parser_core #(
  parameter int MAX_COORD_CHARS = ngp_pkg::MAX_COORD_CHARS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  char_valid,
  output logic                       char_stall,
  input  wire ngp_pkg::char_beat_t   char_beat,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output ngp_pkg::result_beat_t      result_beat
);
  import ngp_pkg::*;

  // Parser state. Every byte updates it in a single pass of logic; the
  // end_of_line byte also produces the verdict from the updated values and
  // puts the state back to its reset values for the next line.
  phase_t      phase, phase_next;
  logic [7:0]  run_xor, run_xor_next;
  logic [3:0]  hi_nib, hi_nib_next;
  logic [4:0]  fld, fld_next;
  logic [4:0]  cif, cif_next;
  logic        err, err_next;
  logic [3:0]  qual, qual_next;
  logic        qual_ok, qual_ok_next;
  logic [6:0]  sats, sats_next;
  logic [7:0]  deg, deg_next;
  logic [6:0]  mins, mins_next;
  logic        mnz, mnz_next;
  logic        pos_ok, pos_ok_next;
  logic        south, south_next;
  logic        west, west_next;
  logic [7:0]  lat [MAX_COORD_CHARS];
  logic [7:0]  lat_next [MAX_COORD_CHARS];
  logic [7:0]  lon [MAX_COORD_CHARS];
  logic [7:0]  lon_next [MAX_COORD_CHARS];

  result_beat_t result_next;

  logic        acc;
  logic [7:0]  c;
  logic        last;
  logic [4:0]  hx;
  logic        close_fail;
  logic        close_pos_bad;
  logic        is_lon;
  logic        dot_lat;
  logic        dot_lon;
  logic        ok;
  coord_upd_t  cupd;

  logic [7:0]  lat_pk [TEXT_CHARS];
  logic [7:0]  lon_pk [TEXT_CHARS];
  logic [63:0] lat_head, lon_head;
  logic [55:0] lat_tail, lon_tail;
  logic [3:0]  lat_len, lon_len;

  // A new byte waits only while the output register holds an untaken result.
  assign char_stall = result_valid & result_stall;
  assign acc  = char_valid & ~char_stall;
  assign c    = char_beat.char_byte;
  assign last = char_beat.end_of_line;
  assign hx   = hex_decode(c);
  assign is_lon = (fld == FLD_LON);

  // A dot in the degree/minute boundary slot marks the fraction of the minutes.
  always_comb begin
    dot_lat = 1'b0;
    dot_lon = 1'b0;
    for (int i = 0; i < MAX_COORD_CHARS; i++) begin
      if (i == 4) dot_lat = (lat[i] == CH_DOT);
      if (i == 5) dot_lon = (lon[i] == CH_DOT);
    end
  end

  ngp_coord #(
    .MAX_COORD_CHARS(MAX_COORD_CHARS)
  ) u_coord (
    .idx       (cif),
    .c         (c),
    .is_lon    (is_lon),
    .deg       (deg),
    .mins      (mins),
    .dot_at_dig(is_lon ? dot_lon : dot_lat),
    .upd       (cupd)
  );

  // Checks made when the current field is closed by a comma or the star.
  always_comb begin
    close_fail    = 1'b0;
    close_pos_bad = 1'b0;
    case (fld)
      FLD_TALKER: close_fail = (cif != 5'd5);
      FLD_LAT: close_pos_bad = (cif < 5'd4) || (mins >= 7'd60) || (deg > 8'd90) ||
                               (deg == 8'd90 && mnz);
      FLD_LON: close_pos_bad = (cif < 5'd5) || (mins >= 7'd60) || (deg > 8'd180) ||
                               (deg == 8'd180 && mnz);
      FLD_NS, FLD_EW: close_pos_bad = (cif != 5'd1);
      FLD_QUAL: close_fail = (cif != 5'd1) || !qual_ok;
      default: ;
    endcase
  end

  // Next state for one accepted byte.
  always_comb begin
    phase_next   = phase;
    run_xor_next = run_xor;
    hi_nib_next  = hi_nib;
    fld_next     = fld;
    cif_next     = cif;
    err_next     = err;
    qual_next    = qual;
    qual_ok_next = qual_ok;
    sats_next    = sats;
    deg_next     = deg;
    mins_next    = mins;
    mnz_next     = mnz;
    pos_ok_next  = pos_ok;
    south_next   = south;
    west_next    = west;
    lat_next     = lat;
    lon_next     = lon;

    case (phase)
      PH_DOLLAR: begin
        if (c == CH_DOLLAR) phase_next = PH_BODY;
        else begin
          err_next = 1'b1;
          phase_next = PH_ENDED;
        end
      end
      PH_BODY: begin
        if (c == CH_NUL) begin
          err_next = 1'b1;
          phase_next = PH_ENDED;
        end else if (c == CH_STAR) begin
          // The star closes the last field; it is not part of the checksum.
          if (close_fail || fld < FLD_MIN_LAST) begin
            err_next = 1'b1;
            phase_next = PH_ENDED;
          end else begin
            if (close_pos_bad) pos_ok_next = 1'b0;
            phase_next = PH_HEX1;
          end
        end else begin
          run_xor_next = run_xor ^ c;
          if (c == CH_COMMA) begin
            if (close_fail || ({1'b0, fld} + 6'd1 >= 6'(MAX_FIELDS))) begin
              err_next = 1'b1;
              phase_next = PH_ENDED;
            end else begin
              if (close_pos_bad) pos_ok_next = 1'b0;
              fld_next  = fld + 5'd1;
              cif_next  = 5'd0;
              deg_next  = 8'd0;
              mins_next = 7'd0;
              mnz_next  = 1'b0;
            end
          end else begin
            case (fld)
              FLD_TALKER: begin
                if ((cif == 5'd2 && c != CH_UG) || (cif == 5'd3 && c != CH_UG) ||
                    (cif == 5'd4 && c != CH_UA)) begin
                  err_next = 1'b1;
                  phase_next = PH_ENDED;
                end
              end
              FLD_LAT, FLD_LON: begin
                if (cupd.pos_bad) pos_ok_next = 1'b0;
                deg_next  = cupd.deg;
                mins_next = cupd.mins;
                if (cupd.mnz_set) mnz_next = 1'b1;
                for (int i = 0; i < MAX_COORD_CHARS; i++) begin
                  if (cupd.wr_en && cif == 5'(i)) begin
                    if (is_lon) lon_next[i] = c;
                    else        lat_next[i] = c;
                  end
                end
              end
              FLD_NS: begin
                if (cif != 5'd0 || (c != CH_UN && c != CH_US)) pos_ok_next = 1'b0;
                else south_next = (c == CH_US);
              end
              FLD_EW: begin
                if (cif != 5'd0 || (c != CH_UE && c != CH_UW)) pos_ok_next = 1'b0;
                else west_next = (c == CH_UW);
              end
              FLD_QUAL: begin
                if (cif != 5'd0 || c < CH_ZERO || c > CH_EIGHT) begin
                  err_next = 1'b1;
                  phase_next = PH_ENDED;
                end else begin
                  qual_next    = 4'(c - CH_ZERO);
                  qual_ok_next = 1'b1;
                end
              end
              FLD_SATS: begin
                if (cif >= 5'd2 || c < CH_ZERO || c > CH_NINE) begin
                  err_next = 1'b1;
                  phase_next = PH_ENDED;
                end else begin
                  sats_next = 7'(11'(sats) * 11'd10 + 11'(c - CH_ZERO));
                end
              end
              default: ;
            endcase
            if (cif < 5'd31) cif_next = cif + 5'd1;
          end
        end
      end
      PH_HEX1: begin
        if (!hx[4]) begin
          err_next = 1'b1;
          phase_next = PH_ENDED;
        end else begin
          hi_nib_next = hx[3:0];
          phase_next  = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!hx[4] || {hi_nib, hx[3:0]} != run_xor) begin
          err_next = 1'b1;
          phase_next = PH_ENDED;
        end else phase_next = PH_TAIL;
      end
      PH_TAIL: begin
        if (c == CH_NUL) phase_next = PH_ENDED;
        else if (c == CH_CR) phase_next = PH_TAIL_CR;
        else if (c == CH_LF) phase_next = PH_TAIL_DONE;
        else begin
          err_next = 1'b1;
          phase_next = PH_ENDED;
        end
      end
      PH_TAIL_CR: begin
        if (c == CH_NUL) phase_next = PH_ENDED;
        else if (c == CH_LF) phase_next = PH_TAIL_DONE;
        else begin
          err_next = 1'b1;
          phase_next = PH_ENDED;
        end
      end
      PH_TAIL_DONE: begin
        if (c == CH_NUL) phase_next = PH_ENDED;
        else begin
          err_next = 1'b1;
          phase_next = PH_ENDED;
        end
      end
      default: ;
    endcase
  end

  // Captured text, padded with zeros to the full output width.
  always_comb begin
    for (int i = 0; i < TEXT_CHARS; i++) begin
      lat_pk[i] = 8'd0;
      lon_pk[i] = 8'd0;
    end
    for (int j = 0; j < MAX_COORD_CHARS; j++) begin
      lat_pk[j] = lat_next[j];
      lon_pk[j] = lon_next[j];
    end
  end

  ngp_pack u_pack_lat (.chars(lat_pk), .head(lat_head), .tail(lat_tail), .len(lat_len));
  ngp_pack u_pack_lon (.chars(lon_pk), .head(lon_head), .tail(lon_tail), .len(lon_len));

  // Verdict. A line passes when it reached the tail with no error, and a
  // nonzero quality also needs a good position. A failed line reports zeros.
  always_comb begin
    ok = !err_next && (phase_next inside {PH_TAIL, PH_TAIL_CR, PH_TAIL_DONE, PH_ENDED});
    if (qual_next != 4'd0 && !pos_ok_next) ok = 1'b0;
    result_next = '0;
    if (ok) begin
      result_next.fix_valid       = 1'b1;
      result_next.fix_quality     = qual_next;
      result_next.satellite_count = sats_next;
      if (qual_next != 4'd0) begin
        result_next.south_flag    = south_next;
        result_next.west_flag     = west_next;
        result_next.lat_text_head = lat_head;
        result_next.lat_text_tail = lat_tail;
        result_next.lat_length    = lat_len;
        result_next.lon_text_head = lon_head;
        result_next.lon_text_tail = lon_tail;
        result_next.lon_length    = lon_len;
      end
    end
  end

  // State registers. The text stores are cleared with the rest so that each
  // line starts with empty coordinate text.
  always_ff @(posedge clk) begin
    if (rst || (acc && last)) begin
      phase   <= PH_DOLLAR;
      run_xor <= 8'd0;
      hi_nib  <= 4'd0;
      fld     <= 5'd0;
      cif     <= 5'd0;
      err     <= 1'b0;
      qual    <= 4'd0;
      qual_ok <= 1'b0;
      sats    <= 7'd0;
      deg     <= 8'd0;
      mins    <= 7'd0;
      mnz     <= 1'b0;
      pos_ok  <= 1'b1;
      south   <= 1'b0;
      west    <= 1'b0;
      for (int i = 0; i < MAX_COORD_CHARS; i++) begin
        lat[i] <= 8'd0;
        lon[i] <= 8'd0;
      end
    end else if (acc) begin
      phase   <= phase_next;
      run_xor <= run_xor_next;
      hi_nib  <= hi_nib_next;
      fld     <= fld_next;
      cif     <= cif_next;
      err     <= err_next;
      qual    <= qual_next;
      qual_ok <= qual_ok_next;
      sats    <= sats_next;
      deg     <= deg_next;
      mins    <= mins_next;
      mnz     <= mnz_next;
      pos_ok  <= pos_ok_next;
      south   <= south_next;
      west    <= west_next;
      lat     <= lat_next;
      lon     <= lon_next;
    end
  end

  // Output register: loads on the last byte of a line, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (acc && last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && last) result_beat <= result_next;
  end

endmodule
`default_nettype wire

[src/ngp_checker.sv]
// Port-level checks for the GGA sentence parser, bound to the top level.
// Depends on ngp_pkg and nmea_gga_sentence_parser_core.
`default_nettype none
module ngp_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  char_valid,
  input wire logic                  char_stall,
  input wire ngp_pkg::char_beat_t   char_beat,
  input wire logic                  result_valid,
  input wire logic                  result_stall,
  input wire ngp_pkg::result_beat_t result_beat
);
  import ngp_pkg::*;

  // A stalled byte beat stays put until it is taken.
  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_beat))
    else $error("stalled byte beat changed");

  // A stalled result stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_beat))
    else $error("stalled result beat changed");

  // A failed line reports nothing but zeros.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_beat.fix_valid |->
      result_beat.fix_quality == 4'd0 && result_beat.satellite_count == 7'd0 &&
      result_beat.lat_length == 4'd0 && result_beat.lon_length == 4'd0 &&
      !result_beat.south_flag && !result_beat.west_flag)
    else $error("failed line carries data");

  // Without a fix there is no position.
  a_no_fix_no_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_beat.fix_quality == 4'd0 |->
      result_beat.lat_length == 4'd0 && result_beat.lon_length == 4'd0 &&
      result_beat.lat_text_head == 64'd0 && result_beat.lon_text_head == 64'd0)
    else $error("position reported without a fix");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind nmea_gga_sentence_parser_core ngp_checker u_ngp_checker (
  .clk         (clk),
  .rst         (rst),
  .char_valid  (char_valid),
  .char_stall  (char_stall),
  .char_beat   (char_beat),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result_beat (result_beat)
);
`default_nettype wire

[tb/tb_nmea_gga_sentence_parser_core.sv]
// Self-checking testbench for the GGA sentence parser core.
// Depends on ngp_pkg and the RTL of nmea_gga_sentence_parser_core.
`timescale 1ns / 1ps
module tb_nmea_gga_sentence_parser_core;
  import ngp_pkg::*;

  // Phase codes of the local predictor.
  typedef enum logic [2:0] {
    P_DOLLAR, P_BODY, P_HEX1, P_HEX2, P_TAIL, P_TAIL_CR, P_TAIL_DONE, P_ENDED
  } gga_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic char_stall;
  char_beat_t char_beat = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_beat_t result_beat;

  always #5 clk = ~clk;

  nmea_gga_sentence_parser_core DUT (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_beat(char_beat),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_beat(result_beat)
  );

  // The predictor keeps its own copy of the parser state.
  gga_phase_e phase;
  logic [7:0] chk_xor;
  logic [3:0] hi_nib;
  int unsigned fld_no, fld_pos;
  bit line_bad, qual_seen, pos_good, min_nz;
  int unsigned qual_val, sat_val, deg_acc, min_int;
  logic [7:0] lat_txt [15];
  logic [7:0] lon_txt [15];
  logic [7:0] ns_letter, ew_letter;

  result_beat_t fix_queue[$];
  int mismatches = 0;
  int burst_left = 0;
  int items_sent = 0;

  function automatic void clear_parser();
    phase = P_DOLLAR; chk_xor = '0; hi_nib = '0;
    fld_no = 0; fld_pos = 0; line_bad = 0; qual_val = 0; qual_seen = 0;
    sat_val = 0; deg_acc = 0; min_int = 0; min_nz = 0; pos_good = 1;
    for (int i = 0; i < 15; i++) begin
      lat_txt[i] = '0;
      lon_txt[i] = '0;
    end
    ns_letter = '0; ew_letter = '0;
  endfunction

  function automatic void reject_line();
    line_bad = 1; phase = P_ENDED;
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  // One coordinate character; dp is the index where the decimal point may sit.
  function automatic void coord_digit(bit is_lat, int unsigned idx, logic [7:0] c,
                                      int unsigned dp);
    int unsigned d, v;
    logic [7:0] at_dp;
    if (idx >= 15) begin
      pos_good = 0;
      return;
    end
    if (is_lat) lat_txt[idx] = c; else lon_txt[idx] = c;
    if (c < "0" || c > "9") begin
      if (!(idx == dp && c == CH_DOT)) pos_good = 0;
      return;
    end
    d = c - "0";
    if (idx < dp - 2) begin
      v = deg_acc * 10 + d;
      deg_acc = v > 255 ? 255 : v;
    end else begin
      if (d != 0) min_nz = 1;
      at_dp = is_lat ? lat_txt[dp] : lon_txt[dp];
      if (!(idx > dp && at_dp == CH_DOT)) begin
        v = min_int * 10 + d;
        min_int = v > 127 ? 127 : v;
      end
    end
  endfunction

  function automatic void coord_end(int unsigned dp, int unsigned max_deg);
    if (fld_pos < dp || min_int >= 60 || deg_acc > max_deg ||
        (deg_acc == max_deg && min_nz)) pos_good = 0;
  endfunction

  function automatic void field_done();
    case (fld_no)
      0: if (fld_pos != 5) reject_line();
      2: coord_end(4, 90);
      3, 5: if (fld_pos != 1) pos_good = 0;
      4: coord_end(5, 180);
      6: if (fld_pos != 1 || !qual_seen) reject_line();
      default: ;
    endcase
  endfunction

  function automatic void field_byte(logic [7:0] c);
    int unsigned idx;
    idx = fld_pos;
    case (fld_no)
      0: if ((idx == 2 && c != CH_UG) || (idx == 3 && c != CH_UG) ||
             (idx == 4 && c != CH_UA)) reject_line();
      2: coord_digit(1, idx, c, 4);
      4: coord_digit(0, idx, c, 5);
      3: if (idx != 0 || (c != CH_UN && c != CH_US)) pos_good = 0;
         else ns_letter = c;
      5: if (idx != 0 || (c != CH_UE && c != CH_UW)) pos_good = 0;
         else ew_letter = c;
      6: if (idx != 0 || c < CH_ZERO || c > CH_EIGHT) reject_line();
         else begin
           qual_val = c - CH_ZERO;
           qual_seen = 1;
         end
      7: if (idx >= 2 || c < CH_ZERO || c > CH_NINE) reject_line();
         else sat_val = sat_val * 10 + (c - CH_ZERO);
      default: ;
    endcase
    if (fld_pos < 31) fld_pos++;
  endfunction

  function automatic void body_char(logic [7:0] c);
    if (c == CH_NUL) begin
      reject_line();
      return;
    end
    if (c == CH_STAR) begin
      field_done();
      if (line_bad) return;
      if (fld_no < 9) reject_line(); else phase = P_HEX1;
      return;
    end
    chk_xor ^= c;
    if (c == CH_COMMA) begin
      field_done();
      if (line_bad) return;
      if (fld_no + 1 >= MAX_FIELDS) begin
        reject_line();
        return;
      end
      fld_no++; fld_pos = 0; deg_acc = 0; min_int = 0; min_nz = 0;
      return;
    end
    field_byte(c);
  endfunction

  function automatic void pack_coord(bit is_lat, output logic [63:0] head,
                                     output logic [55:0] tail, output logic [3:0] len);
    int n;
    logic [7:0] ch;
    head = '0; tail = '0; n = 0;
    for (int i = 0; i < 15; i++) begin
      ch = is_lat ? lat_txt[i] : lon_txt[i];
      if (ch == 8'd0) break;
      if (i < 8) head[8*(7-i) +: 8] = ch; else tail[8*(14-i) +: 8] = ch;
      n++;
    end
    len = n[3:0];
  endfunction

  // Advances the predictor by one byte; on the last byte queues the verdict.
  function automatic void predict_fix(char_beat_t b);
    result_beat_t r;
    logic [7:0] c;
    int h;
    bit ok;
    c = b.char_byte;
    case (phase)
      P_DOLLAR: if (c == CH_DOLLAR) phase = P_BODY; else reject_line();
      P_BODY: body_char(c);
      P_HEX1: begin
        h = hex_nibble(c);
        if (h < 0) reject_line();
        else begin
          hi_nib = h[3:0];
          phase = P_HEX2;
        end
      end
      P_HEX2: begin
        h = hex_nibble(c);
        if (h < 0 || {hi_nib, h[3:0]} != chk_xor) reject_line(); else phase = P_TAIL;
      end
      P_TAIL: if (c == CH_NUL) phase = P_ENDED;
              else if (c == CH_CR) phase = P_TAIL_CR;
              else if (c == CH_LF) phase = P_TAIL_DONE;
              else reject_line();
      P_TAIL_CR: if (c == CH_NUL) phase = P_ENDED;
                 else if (c == CH_LF) phase = P_TAIL_DONE;
                 else reject_line();
      P_TAIL_DONE: if (c == CH_NUL) phase = P_ENDED; else reject_line();
      default: ;
    endcase
    if (!b.end_of_line) return;
    r = '0;
    ok = !line_bad && phase >= P_TAIL;
    if (ok && qual_val != 0 && !pos_good) ok = 0;
    if (ok) begin
      r.fix_valid = 1'b1;
      r.fix_quality = qual_val[3:0];
      r.satellite_count = sat_val[6:0];
      if (qual_val != 0) begin
        r.south_flag = (ns_letter == CH_US);
        r.west_flag = (ew_letter == CH_UW);
        pack_coord(1, r.lat_text_head, r.lat_text_tail, r.lat_length);
        pack_coord(0, r.lon_text_head, r.lon_text_tail, r.lon_length);
      end
    end
    fix_queue.push_back(r);
    clear_parser();
  endfunction

  // Sends one byte beat. The sender idles in bursts: a gap of random length is
  // taken whenever the current burst runs out.
  task automatic send_char(logic [7:0] c, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    char_valid <= 1'b1;
    char_beat <= '{char_byte: c, end_of_line: last};
    @(posedge clk);
    while (char_stall) @(posedge clk);
    items_sent++;
    predict_fix('{char_byte: c, end_of_line: last});
  endtask

  // Sends a string; end_of_line goes on its last byte only when close is set.
  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_char(s[i], close && (i == s.len() - 1));
  endtask

  // Sends a string as one line; the last byte carries end_of_line.
  task automatic send_line(string s);
    send_text(s, 1'b1);
  endtask

  function automatic string hex2(logic [7:0] v);
    return $sformatf("%02X", v);
  endfunction

  function automatic logic [7:0] body_xor(string s);
    logic [7:0] x;
    x = '0;
    for (int i = 0; i < s.len(); i++) x ^= s[i];
    return x;
  endfunction

  // Wraps a body into a full sentence with a correct checksum and an optional tail.
  function automatic string wrap(string body, int tail_kind);
    string t;
    case (tail_kind)
      0: t = "";
      1: t = "\r";
      2: t = "\n";
      default: t = "\r\n";
    endcase
    return {"$", body, "*", hex2(body_xor(body)), t};
  endfunction

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  // Degree value padded to two or three digits.
  function automatic string deg_text(int dd, int v);
    return (dd == 2) ? $sformatf("%02d", v) : $sformatf("%03d", v);
  endfunction

  // A random but mostly well formed coordinate with dd (or ddd) degree digits.
  function automatic string rand_coord(int dd, int max_deg);
    string s;
    int deg, mn;
    case ($urandom_range(0, 9))
      0: return digits($urandom_range(0, 16));
      1: return {digits(dd + 2), ".", digits($urandom_range(8, 12))};
      2: return {deg_text(dd, max_deg), $sformatf("%02d.", $urandom_range(0, 1)),
                 digits($urandom_range(0, 3))};
      3: return {digits(dd + 2), "x", digits(2)};
      4: return {digits(dd), $sformatf("%0d", $urandom_range(55, 130)), ".5"};
      default: begin
        deg = $urandom_range(0, max_deg);
        mn = $urandom_range(0, 59);
        s = {deg_text(dd, deg), $sformatf("%02d", mn)};
        if ($urandom_range(0, 3) != 0) s = {s, ".", digits($urandom_range(0, 7))};
        return s;
      end
    endcase
  endfunction

  function automatic string rand_body();
    string f [$];
    string b;
    int nf;
    f.push_back($urandom_range(0, 9) == 0 ? string'("GPGSA") :
                ($urandom_range(0, 1) ? string'("GPGGA") : string'("GNGGA")));
    f.push_back(digits(6));
    f.push_back(rand_coord(2, 90));
    f.push_back($urandom_range(0, 9) == 0 ? string'("Q") :
                ($urandom_range(0, 1) ? string'("N") : string'("S")));
    f.push_back(rand_coord(3, 180));
    f.push_back($urandom_range(0, 9) == 0 ? string'("EE") :
                ($urandom_range(0, 1) ? string'("E") : string'("W")));
    f.push_back($urandom_range(0, 12) == 0 ? string'("9") :
                string'(8'("0" + $urandom_range(0, 8))));
    f.push_back($urandom_range(0, 12) == 0 ? digits(3) : digits($urandom_range(0, 2)));
    nf = $urandom_range(0, 12) == 0 ? $urandom_range(8, 18) : $urandom_range(10, 16);
    while (f.size() < nf) f.push_back($urandom_range(0, 1) ? digits(3) : string'(""));
    b = f[0];
    for (int i = 1; i < nf && i < f.size(); i++) b = {b, ",", f[i]};
    return b;
  endfunction

  task automatic test_directed();
    string b;
    b = "GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,";
    send_line(wrap(b, 3));
    send_line(wrap(b, 0));
    send_line(wrap(b, 1));
    send_line(wrap(b, 2));
    send_line({"$", b, "*", $sformatf("%02x", body_xor(b)), "\r\n"});
    send_line({"$", b, "*", hex2(body_xor(b) ^ 8'h01)});
    send_line({wrap(b, 3), "X"});
    send_line({wrap(b, 2), "\r"});
    // A zero byte after the checksum ends the string; the rest is ignored.
    send_text(wrap(b, 0), 1'b0);
    send_char(CH_NUL, 1'b0);
    send_text("junk", 1'b1);
    // A zero byte inside the body fails the line.
    send_text("$GPGGA,1", 1'b0);
    send_char(CH_NUL, 1'b0);
    send_text("2", 1'b1);
    send_line({"#", b});
    send_line(wrap("GPGGA,0,9000.000,S,18000.000,W,8,99,1,2,M,3,M,4,5,6", 3));
    send_line(wrap("GPGGA,0,9000.001,S,18000.000,W,2,7,1,2,M,3,M,4,5,6,7", 3));
    send_line(wrap("GPGGA,0,1234.5678901234567,N,12345.1,E,1,,1,2", 3));
    send_line(wrap("GPGGA,0,0060.0,N,00059.9,E,1,5,1,2", 0));
    send_line(wrap("GPGGA,0,,,,,0,,1,2", 0));
    send_line(wrap("GPGGA,0,bad,X,bad,Y,0,12,1,2", 0));
    send_line(wrap("GPGGA,0,,,,,0,,1", 0));
    send_line(wrap("GPRMC,0,,,,,0,,1,2", 0));
    send_line(wrap("GPGGA,0,,,,,9,,1,2", 0));
    send_line(wrap("GPGGA,0,,,,,1,123,1,2", 0));
    send_line(wrap("GPGGA,0,9999999999.9,N,999999999999.0,E,1,1,1,2", 0));
    send_line({"$", b, "*", "g0"});
    send_char(8'hFF, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);
  endtask

  task automatic test_random_lines();
    string s;
    while (items_sent < 1400) begin
      case ($urandom_range(0, 19))
        0: begin
          s = "";
          for (int i = $urandom_range(1, 12); i > 0; i--)
            s = {s, string'(8'($urandom_range(1, 255)))};
          send_text(s, 1'b0);
          send_char(8'($urandom_range(0, 255)), 1'b1);
        end
        1: begin
          s = wrap(rand_body(), $urandom_range(0, 3));
          s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
          send_line(s);
        end
        default: send_line(wrap(rand_body(), $urandom_range(0, 3)));
      endcase
    end
  endtask

  // The receiver stalls on its own pattern: quiet spells and busy spells.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9:8] == 2'd0) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(0, 2) == 0);
  end

  // Result checker.
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && result_valid && !result_stall) begin
      if (fix_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", result_beat);
      end else begin
        want = fix_queue.pop_front();
        if (result_beat !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %h, got %h", want, result_beat);
        end
      end
    end
  end

  initial begin
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_lines();
    char_valid <= 1'b0;
    while (fix_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/ngp_pkg.sv
src/ngp_coord.sv
src/ngp_pack.sv
src/nmea_gga_sentence_parser_core.sv
src/ngp_checker.sv
tb/tb_nmea_gga_sentence_parser_core.sv
